[rtl/tws_pkg.sv]
// shared types, codes and constants for the three-wire spi register/fifo master
// no dependencies
package tws_pkg;

    localparam int TICK_BITS = 8;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SETUPA = 4'd1;
    localparam logic [3:0] PH_SETUPB = 4'd2;
    localparam logic [3:0] PH_LOW    = 4'd3;
    localparam logic [3:0] PH_HIGH   = 4'd4;
    localparam logic [3:0] PH_TAILA  = 4'd5;
    localparam logic [3:0] PH_TAILB  = 4'd6;
    localparam logic [3:0] PH_HOLD   = 4'd7;
    localparam logic [3:0] PH_GAP    = 4'd8;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_REG_WR  = 3'd1;
    localparam logic [2:0] OP_REG_RD  = 3'd2;
    localparam logic [2:0] OP_FIFO_WR = 3'd3;
    localparam logic [2:0] OP_FIFO_RD = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIFO_HOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIFO_GAP    = 2'd2;

    localparam logic [16:0] CNT_MAX = 17'((1 << TICK_BITS) - 1);

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] fifo_hold_ticks;
        logic [7:0] fifo_gap_ticks;
    } tws_cfg_t;

    typedef struct packed {
        logic [3:0]           phase;
        logic [2:0]           kind;
        logic [2:0]           bit_index;
        logic                 byte_index;
        logic [7:0]           shift_byte;
        logic [7:0]           data_hold;
        logic [TICK_BITS-1:0] wait_count;
        logic                 csb;
        logic                 fcsb;
        logic                 sclk;
        logic                 sdio;
        logic                 drive;
        logic [7:0]           received;
    } tws_state_t;

    localparam tws_state_t STATE_RESET = '{
        phase:      PH_IDLE,
        kind:       OP_NONE,
        bit_index:  3'd0,
        byte_index: 1'b0,
        shift_byte: 8'd0,
        data_hold:  8'd0,
        wait_count: '0,
        csb:        1'b1,
        fcsb:       1'b1,
        sclk:       1'b0,
        sdio:       1'b1,
        drive:      1'b0,
        received:   8'd0
    };

    // wait load, clipped to the counter range
    function automatic logic [TICK_BITS-1:0] sat_wait(input logic [7:0] d);
        logic [16:0] wide;
        logic [16:0] res;
        begin
            wide = {9'd0, d};
            res  = (wide > CNT_MAX) ? CNT_MAX : wide;
            return res[TICK_BITS-1:0];
        end
    endfunction

endpackage

[rtl/tws_cfg.sv]
// timing configuration registers of the three-wire spi master
// depends on tws_pkg
module tws_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data,
    output tws_pkg::tws_cfg_t                 cfg
);

    tws_pkg::tws_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= 8'd1;
            cfg_reg.fifo_hold_ticks   <= 8'd3;
            cfg_reg.fifo_gap_ticks    <= 8'd6;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tws_pkg::CFG_HALF_PERIOD)
            begin
                cfg_reg.half_period_ticks <= cfg_data;
            end
            else if (cfg_index == tws_pkg::CFG_FIFO_HOLD)
            begin
                cfg_reg.fifo_hold_ticks <= cfg_data;
            end
            else if (cfg_index == tws_pkg::CFG_FIFO_GAP)
            begin
                cfg_reg.fifo_gap_ticks <= cfg_data;
            end
        end
    end

endmodule

[rtl/tws_step.sv]
// one-tick next-state logic of the three-wire spi master sequencer
// depends on tws_pkg
module tws_step
(
    input  tws_pkg::tws_state_t cur,
    input  tws_pkg::tws_cfg_t   cfg,
    input  logic [2:0]          operation,
    input  logic [6:0]          reg_address,
    input  logic [7:0]          write_data,
    input  logic                sdio_in,
    output tws_pkg::tws_state_t nxt,
    output logic                read_done
);

    logic [7:0]                     half_ticks;
    logic [tws_pkg::TICK_BITS-1:0]  half_wait;
    logic                           is_reg;
    logic                           sending;
    logic                           start_op;
    logic                           go_low;
    logic                           go_high;
    logic                           go_tail;
    logic                           go_hold;
    logic                           go_gap;
    logic                           go_fin;
    tws_pkg::tws_state_t            nx;

    assign half_ticks = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    assign half_wait  = tws_pkg::sat_wait(half_ticks - 8'd1);
    assign start_op   = (operation == tws_pkg::OP_REG_WR) || (operation == tws_pkg::OP_REG_RD) ||
                        (operation == tws_pkg::OP_FIFO_WR) || (operation == tws_pkg::OP_FIFO_RD);

    always_comb
    begin
        nx        = cur;
        read_done = 1'b0;
        go_low    = 1'b0;
        go_high   = 1'b0;
        go_tail   = 1'b0;
        go_hold   = 1'b0;
        go_gap    = 1'b0;
        go_fin    = 1'b0;
        is_reg    = (cur.kind == tws_pkg::OP_REG_WR) || (cur.kind == tws_pkg::OP_REG_RD);
        sending   = 1'b0;

        if (cur.phase == tws_pkg::PH_IDLE)
        begin
            if (start_op)
            begin
                nx.kind       = operation;
                nx.data_hold  = write_data;
                nx.bit_index  = 3'd0;
                nx.byte_index = 1'b0;
                nx.sclk       = 1'b0;
                if ((operation == tws_pkg::OP_REG_WR) || (operation == tws_pkg::OP_REG_RD))
                begin
                    nx.shift_byte = {operation == tws_pkg::OP_REG_RD, reg_address};
                    nx.sdio       = 1'b1;
                    nx.drive      = 1'b1;
                    nx.fcsb       = 1'b1;
                    nx.csb        = 1'b0;
                end
                else
                begin
                    nx.shift_byte = (operation == tws_pkg::OP_FIFO_WR) ? write_data : 8'd0;
                    nx.drive      = (operation == tws_pkg::OP_FIFO_WR);
                    nx.csb        = 1'b1;
                    nx.fcsb       = 1'b0;
                end
                nx.phase      = tws_pkg::PH_SETUPA;
                nx.wait_count = half_wait;
            end
        end
        else if (cur.wait_count != '0)
        begin
            nx.wait_count = cur.wait_count - {{(tws_pkg::TICK_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            unique case (cur.phase)
                tws_pkg::PH_SETUPA:
                begin
                    nx.phase      = tws_pkg::PH_SETUPB;
                    nx.wait_count = half_wait;
                end
                tws_pkg::PH_SETUPB:
                begin
                    nx.bit_index  = 3'd0;
                    nx.byte_index = 1'b0;
                    go_low        = 1'b1;
                end
                tws_pkg::PH_LOW:
                begin
                    go_high = 1'b1;
                end
                tws_pkg::PH_HIGH:
                begin
                    if (cur.bit_index != 3'd7)
                    begin
                        nx.bit_index = cur.bit_index + 3'd1;
                        go_low       = 1'b1;
                    end
                    else if (is_reg && !cur.byte_index)
                    begin
                        nx.byte_index = 1'b1;
                        nx.bit_index  = 3'd0;
                        nx.shift_byte = (cur.kind == tws_pkg::OP_REG_WR) ? cur.data_hold : 8'd0;
                        go_low        = 1'b1;
                    end
                    else if (is_reg)
                    begin
                        nx.phase = tws_pkg::PH_TAILA;
                        go_tail  = 1'b1;
                    end
                    else
                    begin
                        go_hold = 1'b1;
                    end
                end
                tws_pkg::PH_TAILA:
                begin
                    nx.phase = tws_pkg::PH_TAILB;
                    go_tail  = 1'b1;
                end
                tws_pkg::PH_HOLD:
                begin
                    go_gap = 1'b1;
                end
                default:
                begin
                    go_fin = 1'b1;
                end
            endcase
        end

        // data pin is driven for writes and for the address byte of a read
        sending = (nx.kind == tws_pkg::OP_REG_WR) || (nx.kind == tws_pkg::OP_FIFO_WR) ||
                  ((nx.kind == tws_pkg::OP_REG_RD) && !nx.byte_index);

        if (go_low)
        begin
            nx.phase      = tws_pkg::PH_LOW;
            nx.sclk       = 1'b0;
            if (sending)
            begin
                nx.sdio  = nx.shift_byte[7];
                nx.drive = 1'b1;
            end
            else
            begin
                nx.drive = 1'b0;
            end
            nx.wait_count = half_wait;
        end

        if (go_high)
        begin
            nx.phase      = tws_pkg::PH_HIGH;
            nx.sclk       = 1'b1;
            nx.shift_byte = sending ? {cur.shift_byte[6:0], 1'b0}
                                    : {cur.shift_byte[6:0], sdio_in};
            nx.wait_count = half_wait;
        end

        if (go_tail)
        begin
            nx.sclk       = 1'b0;
            nx.wait_count = half_wait;
        end

        if (go_hold)
        begin
            nx.phase = tws_pkg::PH_HOLD;
            nx.sclk  = 1'b0;
            if (cfg.fifo_hold_ticks == 8'd0)
            begin
                go_gap = 1'b1;
            end
            else
            begin
                nx.wait_count = tws_pkg::sat_wait(cfg.fifo_hold_ticks - 8'd1);
            end
        end

        if (go_gap)
        begin
            nx.phase = tws_pkg::PH_GAP;
            nx.fcsb  = 1'b1;
            if (cfg.fifo_gap_ticks == 8'd0)
            begin
                go_fin = 1'b1;
            end
            else
            begin
                nx.wait_count = tws_pkg::sat_wait(cfg.fifo_gap_ticks - 8'd1);
            end
        end

        if (go_fin)
        begin
            nx.csb  = 1'b1;
            nx.fcsb = 1'b1;
            nx.sclk = 1'b0;
            if (is_reg)
            begin
                nx.sdio = 1'b1;
            end
            nx.drive = 1'b0;
            if ((cur.kind == tws_pkg::OP_REG_RD) || (cur.kind == tws_pkg::OP_FIFO_RD))
            begin
                nx.received = nx.shift_byte;
                read_done   = 1'b1;
            end
            nx.phase      = tws_pkg::PH_IDLE;
            nx.wait_count = '0;
        end
    end

    assign nxt = nx;

endmodule

[rtl/three_wire_spi_register_fifo_master.sv]
// top level of the three-wire spi master for register and fifo accesses
// depends on tws_pkg, tws_cfg and tws_step
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | one timing tick: command and sdio_in
//  m_*      | out       | m_tvalid/m_tready  | pin levels, busy, read byte, done
//  cfg_*    | in        | cfg_valid/cfg_ready| timing register write
//
// one word per clock cycle while s_tready is high; the sequencer state and the output register
// both update on the cycle a word is accepted
// s_tready is high while the output register is empty or being drained
// reset leaves the sequencer idle with selects high, clock low, data high
// cfg_ready is always high
module three_wire_spi_register_fifo_master
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[2:0], reg_address[9:3], write_data[17:10], sdio_in[18], zero pad
    input  logic [tws_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // csb_level[0], fcsb_level[1], sclk_level[2], sdio_out_level[3], sdio_drive[4],
    // busy_res[5], read_data[13:6], read_done[14], zero pad
    output logic [tws_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);

    tws_pkg::tws_cfg_t      cfg;
    tws_pkg::tws_state_t    state_reg;
    tws_pkg::tws_state_t    state_next;
    logic                   done_next;
    logic                   m_tvalid_reg;
    logic [14:0]            result_reg;
    logic [14:0]            result_next;
    logic                   s_accept;

    tws_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tws_step u_step
    (
        .cur         (state_reg),
        .cfg         (cfg),
        .operation   (s_tdata[2:0]),
        .reg_address (s_tdata[9:3]),
        .write_data  (s_tdata[17:10]),
        .sdio_in     (s_tdata[18]),
        .nxt         (state_next),
        .read_done   (done_next)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign result_next = {done_next, state_next.received,
                          state_next.phase != tws_pkg::PH_IDLE,
                          state_next.drive, state_next.sdio, state_next.sclk,
                          state_next.fcsb, state_next.csb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tws_pkg::STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg};

    // done pulse only on the word that ends a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && result_reg[14]) |-> !result_reg[5])
        else $error("read done while still busy");

    // a stalled result must block new words
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("word accepted over a stalled result");

    // idle with no valid command stays idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (state_reg.phase == tws_pkg::PH_IDLE) &&
         (s_tdata[2:0] == tws_pkg::OP_NONE))
        |=> (state_reg.phase == tws_pkg::PH_IDLE))
        else $error("idle sequencer started without a command");

    // wait counter only runs inside a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.wait_count != '0) |-> (state_reg.phase != tws_pkg::PH_IDLE))
        else $error("wait count left over in idle");

    // state only moves on an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_accept |=> $stable(state_reg))
        else $error("sequencer state moved without a word");

endmodule
